// ===== src/uspp_pkg.sv =====
`default_nettype none
// ============================================================================
// uspp_pkg
// Shared types and constants of the serial gas-sensor poller and CSV parser.
// ============================================================================
package uspp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned LEN_W       = 8;
    localparam int unsigned TOKENS      = 4;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    localparam logic [1:0] EV_TX    = 2'd0;
    localparam logic [1:0] EV_READY = 2'd1;
    localparam logic [1:0] EV_ERROR = 2'd2;

    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT   = 2'd0;
    localparam logic [1:0] CAUSE_OUT_STATE = 2'd1;
    localparam logic [1:0] CAUSE_FEW_VALS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_BYTE = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;
    localparam logic [7:0]  REQ_BYTE_RESET = 8'd13;

    typedef enum logic [1:0] {
        K_TICK    = 2'd0,
        K_BYTE    = 2'd1,
        K_REQUEST = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        C_ZERO  = 3'd0,
        C_COMMA = 3'd1,
        C_SPACE = 3'd2,
        C_PLUS  = 3'd3,
        C_MINUS = 3'd4,
        C_DIGIT = 3'd5,
        C_OTHER = 3'd6
    } t_cls;

    typedef struct packed {
        t_kind      kind;
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_item;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SEND      = 5'b00010,
        ST_REQUESTED = 5'b00100,
        ST_READY     = 5'b01000,
        ST_ERROR     = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        INIT_NONE = 2'd0,
        INIT_BUSY = 2'd1,
        INIT_DONE = 2'd2
    } t_init;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_LEAD    = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

endpackage
`default_nettype wire

// ===== src/uart_sensor_poll_csv_parser.sv =====
`default_nettype none
// ============================================================================
// uart_sensor_poll_csv_parser
// Polls a serial gas sensor and parses its comma-separated response into
// SO2, temperature and humidity readings.
// ============================================================================
//  Channel   Direction  tdata                                 tuser / tlast
//  s_axis    in         [7:0] rx_byte                         tuser operation, tlast rx_last
//  m_axis    out        [7:0] tx_byte, [23:8] so2_ppb,        tuser event_res
//                       [39:24] temp_centi, [55:40] rh_x100,
//                       [57:56] error_cause, [58] initialized
//  cfg       in         i_cfg_idx 0 timeout_ticks, 1 request_byte
//
//  One request is taken every cycle while the queue has room. A result is
//  valid on m_axis after its request is accepted: the request is first
//  written into the queue, then the back end registers its event.
//  The back end's digit multiply-add and timer compare are combinational.
//  Reset is synchronous and clears all control state at once.
//  A stalled output holds the back end, and the two-entry queue absorbs input.
// ============================================================================
module uart_sensor_poll_csv_parser #(
    parameter int unsigned MAX_MESSAGE_BYTES = 255
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [uspp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [uspp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]                        s_axis_tuser,   // [1:0] operation
    input  wire logic                              s_axis_tlast,   // rx_last
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] tx_byte, [23:8] so2_ppb, [39:24] temp_centi, [55:40] rh_x100,
    // [57:56] error_cause, [58] initialized
    output logic [63:0]                            m_axis_tdata,
    output logic [1:0]                             m_axis_tuser    // [1:0] event_res
);
    import uspp_pkg::*;

    logic   w_push;
    t_item  w_in_item;
    logic   w_q_ready;
    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_q_pop;

    uspp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_push        (w_push),
        .o_item        (w_in_item),
        .i_q_ready     (w_q_ready)
    );

    uspp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    uspp_back #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== src/uspp_front.sv =====
`default_nettype none
// ============================================================================
// uspp_front
// Accepts input requests, drops unused operation codes and classifies
// received characters before they enter the queue.
// ============================================================================
module uspp_front (
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]    s_axis_tuser,   // [1:0] operation
    input  wire logic          s_axis_tlast,   // rx_last
    output logic               o_push,
    output uspp_pkg::t_item    o_item,
    input  wire logic          i_q_ready
);
    import uspp_pkg::*;

    t_kind      w_kind;
    t_cls       w_cls;
    logic       w_known;

    always_comb begin
        w_known = 1'b1;
        w_kind  = K_TICK;
        unique case (s_axis_tuser)
            OP_TICK:    w_kind = K_TICK;
            OP_BYTE:    w_kind = K_BYTE;
            OP_REQUEST: w_kind = K_REQUEST;
            default:    w_known = 1'b0;
        endcase
    end

    always_comb begin
        if (s_axis_tdata == 8'h00) begin
            w_cls = C_ZERO;
        end else if (s_axis_tdata == 8'h2C) begin
            w_cls = C_COMMA;
        end else if (s_axis_tdata == 8'h20
                     || (s_axis_tdata >= 8'h09 && s_axis_tdata <= 8'h0D)) begin
            w_cls = C_SPACE;
        end else if (s_axis_tdata == 8'h2B) begin
            w_cls = C_PLUS;
        end else if (s_axis_tdata == 8'h2D) begin
            w_cls = C_MINUS;
        end else if (s_axis_tdata >= 8'h30 && s_axis_tdata <= 8'h39) begin
            w_cls = C_DIGIT;
        end else begin
            w_cls = C_OTHER;
        end
    end

    assign s_axis_tready = i_q_ready;
    assign o_push        = s_axis_tvalid && i_q_ready && w_known;
    assign o_item.kind   = w_kind;
    assign o_item.cls    = w_cls;
    assign o_item.digit  = s_axis_tdata[3:0];
    assign o_item.last   = s_axis_tlast;

endmodule
`default_nettype wire

// ===== src/uspp_queue.sv =====
`default_nettype none
// ============================================================================
// uspp_queue
// Short first-in first-out queue of classified requests between the front
// and the back.
// ============================================================================
module uspp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire uspp_pkg::t_item i_item,
    output logic               o_ready,
    output logic               o_valid,
    output uspp_pkg::t_item    o_item,
    input  wire logic          i_pop
);
    import uspp_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wp;
    logic [PTR_W-1:0]   n_rp;
    logic [CNT_W-1:0]   n_cnt;
    logic               w_do_pop;

    assign o_ready  = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_item   = r_mem[r_rp];
    assign w_do_pop = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_do_pop) begin
            n_rp = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== src/uspp_back.sv =====
`default_nettype none
// ============================================================================
// uspp_back
// Control state machine, response timer and CSV number parser. Takes one
// classified request per cycle unless the output stalls, and registers the resulting event.
// ============================================================================
module uspp_back #(
    parameter int unsigned MAX_MESSAGE_BYTES = 255
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [uspp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [uspp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_q_valid,
    input  wire uspp_pkg::t_item                   i_q_item,
    output logic                                   o_q_pop,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [63:0]                            m_axis_tdata,
    output logic [1:0]                             m_axis_tuser
);
    import uspp_pkg::*;

    t_state             r_state, n_state;
    t_init              r_init, n_init;
    logic [15:0]        r_cnt, n_cnt;
    logic               r_armed, n_armed;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [2:0]         r_tc, n_tc;
    t_phase             r_ph, n_ph;
    logic               r_neg, n_neg;
    logic [31:0]        r_acc, n_acc;
    logic               r_ended, n_ended;
    logic [15:0]        r_pend [3];
    logic [15:0]        r_meas [3];
    logic [15:0]        n_meas [3];
    logic [15:0]        r_timeout;
    logic [7:0]         r_req_byte;

    logic               r_ov;
    logic [1:0]         r_ev, n_ev;
    logic [7:0]         r_tx, n_tx;
    logic [1:0]         r_cause, n_cause;
    logic               r_oinit;
    logic [15:0]        r_om [3];
    logic               n_emit;

    logic               w_pop;
    logic [35:0]        w_dg_sum;
    logic [31:0]        w_dg_acc;
    logic               w_skip;
    logic [2:0]         c_tc;
    t_phase             c_ph;
    logic               c_neg;
    logic [31:0]        c_acc;
    logic               w_ch_ok;
    logic               w_fin_now;
    logic [2:0]         s_tc;
    t_phase             s_ph;
    logic               s_neg;
    logic [31:0]        s_acc;
    t_phase             f_ph;
    logic               f_neg;
    logic [31:0]        f_acc;
    logic [2:0]         f_tc;
    logic               w_fin_en;
    logic               w_pend_we;
    logic [1:0]         w_pend_idx;
    logic [15:0]        w_fin_val;

    assign w_pop   = i_q_valid && (!r_ov || m_axis_tready);
    assign o_q_pop = w_pop;

    // Character step of the number parser, before any token is closed.
    always_comb begin
        w_dg_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 36'(i_q_item.digit);
        w_dg_acc = (w_dg_sum > 36'h080000000) ? 32'h80000000 : w_dg_sum[31:0];
        c_tc   = r_tc;
        c_ph   = r_ph;
        c_neg  = r_neg;
        c_acc  = r_acc;
        w_skip = 1'b0;
        if (r_ph == PH_BETWEEN) begin
            if (r_tc >= 3'(TOKENS)) begin
                w_skip = 1'b1;
            end else begin
                c_tc = r_tc + 3'd1;
                c_ph = PH_LEAD;
            end
        end
        if (!w_skip) begin
            case (c_ph)
                PH_LEAD: begin
                    case (i_q_item.cls)
                        C_SPACE: c_ph = PH_LEAD;
                        C_PLUS:  c_ph = PH_DIGITS;
                        C_MINUS: begin
                            c_neg = 1'b1;
                            c_ph  = PH_DIGITS;
                        end
                        C_DIGIT: begin
                            c_acc = w_dg_acc;
                            c_ph  = PH_DIGITS;
                        end
                        default: c_ph = PH_DONE;
                    endcase
                end
                PH_DIGITS: begin
                    if (i_q_item.cls == C_DIGIT) begin
                        c_acc = w_dg_acc;
                    end else begin
                        c_ph = PH_DONE;
                    end
                end
                default: c_ph = r_ph;
            endcase
        end
    end

    // Token close: at most one real close per byte.
    always_comb begin
        w_ch_ok   = !r_ended && (r_len < LEN_W'(MAX_MESSAGE_BYTES));
        w_fin_now = w_ch_ok && (i_q_item.cls == C_ZERO || i_q_item.cls == C_COMMA);
        if (w_ch_ok && !w_fin_now) begin
            s_tc  = c_tc;
            s_ph  = c_ph;
            s_neg = c_neg;
            s_acc = c_acc;
        end else begin
            s_tc  = r_tc;
            s_ph  = r_ph;
            s_neg = r_neg;
            s_acc = r_acc;
        end
        f_tc  = s_tc;
        f_ph  = w_fin_now ? r_ph  : s_ph;
        f_neg = w_fin_now ? r_neg : s_neg;
        f_acc = w_fin_now ? r_acc : s_acc;
        w_fin_en   = w_fin_now || i_q_item.last;
        w_pend_we  = w_fin_en && (f_ph != PH_BETWEEN) && (f_tc >= 3'd2) && (f_tc <= 3'd4);
        w_pend_idx = 2'(f_tc - 3'd2);
        if (f_neg) begin
            w_fin_val = 16'd0 - f_acc[15:0];
        end else begin
            w_fin_val = f_acc[31] ? 16'hFFFF : f_acc[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_init  = r_init;
        n_cnt   = r_cnt;
        n_armed = r_armed;
        n_len   = r_len;
        n_tc    = r_tc;
        n_ph    = r_ph;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_ended = r_ended;
        n_meas  = r_meas;
        n_emit  = 1'b0;
        n_ev    = EV_TX;
        n_tx    = 8'd0;
        n_cause = CAUSE_NONE;
        if (w_pop) begin
            case (i_q_item.kind)
                K_TICK: begin
                    if (r_armed) begin
                        if (r_cnt != 16'hFFFF) begin
                            n_cnt = r_cnt + 16'd1;
                        end
                        if (n_cnt >= r_timeout) begin
                            n_armed = 1'b0;
                            n_state = ST_ERROR;
                            n_emit  = 1'b1;
                            n_ev    = EV_ERROR;
                            n_cause = CAUSE_TIMEOUT;
                        end
                    end
                    unique case (n_state)
                        ST_SEND: begin
                            n_cnt   = 16'd0;
                            n_armed = 1'b1;
                            n_len   = '0;
                            n_tc    = 3'd0;
                            n_ph    = PH_BETWEEN;
                            n_neg   = 1'b0;
                            n_acc   = 32'd0;
                            n_ended = 1'b0;
                            n_state = ST_REQUESTED;
                            n_emit  = 1'b1;
                            n_ev    = EV_TX;
                            n_tx    = r_req_byte;
                        end
                        ST_REQUESTED: begin
                            n_state = ST_REQUESTED;
                        end
                        ST_READY: begin
                            if (r_init == INIT_BUSY) begin
                                n_init = INIT_DONE;
                            end
                            n_armed = 1'b0;
                            n_state = ST_IDLE;
                        end
                        ST_ERROR: begin
                            n_armed = 1'b0;
                            n_state = ST_IDLE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                            if (r_init != INIT_DONE) begin
                                n_init  = INIT_BUSY;
                                n_state = ST_SEND;
                            end
                        end
                    endcase
                end
                K_BYTE: begin
                    if (r_state != ST_REQUESTED) begin
                        n_len   = '0;
                        n_tc    = 3'd0;
                        n_ph    = PH_BETWEEN;
                        n_neg   = 1'b0;
                        n_acc   = 32'd0;
                        n_ended = 1'b0;
                        if (i_q_item.last) begin
                            n_state = ST_ERROR;
                            n_emit  = 1'b1;
                            n_ev    = EV_ERROR;
                            n_cause = CAUSE_OUT_STATE;
                        end
                    end else begin
                        if (w_ch_ok) begin
                            n_len = r_len + 1'b1;
                            if (i_q_item.cls == C_ZERO) begin
                                n_ended = 1'b1;
                            end
                        end
                        n_tc = s_tc;
                        if (w_fin_en) begin
                            n_ph  = PH_BETWEEN;
                            n_neg = 1'b0;
                            n_acc = 32'd0;
                        end else begin
                            n_ph  = s_ph;
                            n_neg = s_neg;
                            n_acc = s_acc;
                        end
                        if (i_q_item.last) begin
                            if (s_tc >= 3'(TOKENS)) begin
                                for (int i = 0; i < 3; i++) begin
                                    n_meas[i] = (w_pend_we && w_pend_idx == 2'(i))
                                                ? w_fin_val : r_pend[i];
                                end
                                n_state = ST_READY;
                                n_emit  = 1'b1;
                                n_ev    = EV_READY;
                            end else begin
                                n_state = ST_ERROR;
                                n_emit  = 1'b1;
                                n_ev    = EV_ERROR;
                                n_cause = CAUSE_FEW_VALS;
                            end
                            n_len   = '0;
                            n_tc    = 3'd0;
                            n_ph    = PH_BETWEEN;
                            n_neg   = 1'b0;
                            n_acc   = 32'd0;
                            n_ended = 1'b0;
                        end
                    end
                end
                default: begin
                    if (r_state == ST_IDLE) begin
                        n_state = ST_SEND;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_q_item.kind == K_BYTE && r_state == ST_REQUESTED && w_pend_we) begin
            r_pend[w_pend_idx] <= w_fin_val;
        end
        if (w_pop && n_emit) begin
            r_ev    <= n_ev;
            r_tx    <= n_tx;
            r_cause <= n_cause;
            r_oinit <= (r_init == INIT_DONE);
            r_om    <= n_meas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_init     <= INIT_NONE;
            r_cnt      <= 16'd0;
            r_armed    <= 1'b0;
            r_len      <= '0;
            r_tc       <= 3'd0;
            r_ph       <= PH_BETWEEN;
            r_neg      <= 1'b0;
            r_acc      <= 32'd0;
            r_ended    <= 1'b0;
            r_meas     <= '{default: 16'd0};
            r_timeout  <= TIMEOUT_RESET;
            r_req_byte <= REQ_BYTE_RESET;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
            r_len   <= n_len;
            r_tc    <= n_tc;
            r_ph    <= n_ph;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_ended <= n_ended;
            r_meas  <= n_meas;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                    CFG_REQ_BYTE: r_req_byte <= i_cfg_data[7:0];
                    default:      r_timeout  <= r_timeout;
                endcase
            end
            if (w_pop && n_emit) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ev;
    assign m_axis_tdata  = {5'd0, r_oinit, r_cause, r_om[2], r_om[1], r_om[0], r_tx};

endmodule
`default_nettype wire

// ===== tb/uart_sensor_poll_csv_parser_tb.sv =====
`default_nettype none
// ============================================================================
// uart_sensor_poll_csv_parser_tb
// Runs sensor polls through the poller and checks every transmit, measurement
// and error event against a cycle-free model of the control machine and the
// comma-separated response parser. Directed polls cover reset defaults, error
// causes and timeout limits. Random polls follow under several register
// settings, with random gaps on the request side and stalls on the result side.
// ============================================================================
module uart_sensor_poll_csv_parser_tb;
    import uspp_pkg::*;

    localparam int unsigned MSG_MAX       = 255;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 1050;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct {
        logic [1:0]  ev;
        logic [7:0]  tx;
        logic [15:0] so2;
        logic [15:0] temp;
        logic [15:0] rh;
        logic [1:0]  cause;
        logic        init_done;
    } t_sensor_event;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    // Poller model state.
    logic [15:0] cfg_timeout  = TIMEOUT_RESET;
    logic [7:0]  cfg_req_byte = REQ_BYTE_RESET;
    t_state      ctl          = ST_IDLE;
    t_init       init_step    = INIT_NONE;
    logic [15:0] tmr_count    = '0;
    logic        tmr_armed    = 1'b0;
    logic [7:0]  msg_len      = '0;
    logic [2:0]  tok_cnt      = '0;
    t_phase      tok_phase    = PH_BETWEEN;
    logic        tok_neg      = 1'b0;
    logic [31:0] tok_mag      = '0;
    logic        str_ended    = 1'b0;
    logic [15:0] parsed_vals [3] = '{default: '0};
    logic [15:0] reading     [3] = '{default: '0};

    t_sensor_event awaited_events[$];
    logic [7:0]    msg_buf[$];

    int unsigned mismatches  = 0;
    int unsigned poll_items  = 0;
    int unsigned stall_left  = 0;
    bit          src_gaps    = 1'b1;
    bit          sink_stalls = 1'b1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    uart_sensor_poll_csv_parser #(
        .MAX_MESSAGE_BYTES(MSG_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_event(input logic [1:0] ev, input logic [7:0] tx,
                              input logic [1:0] cause);
        t_sensor_event e;
        e.ev        = ev;
        e.tx        = tx;
        e.so2       = reading[0];
        e.temp      = reading[1];
        e.rh        = reading[2];
        e.cause     = cause;
        e.init_done = (init_step == INIT_DONE);
        awaited_events.push_back(e);
    endtask

    task automatic parser_reset();
        msg_len   = '0;
        tok_cnt   = '0;
        tok_phase = PH_BETWEEN;
        tok_neg   = 1'b0;
        tok_mag   = '0;
        str_ended = 1'b0;
    endtask

    task automatic token_close();
        logic [31:0] mag;
        logic [31:0] val;
        if (tok_phase != PH_BETWEEN) begin
            if (tok_neg) begin
                mag = (tok_mag > 32'h8000_0000) ? 32'h8000_0000 : tok_mag;
                val = 32'd0 - mag;
            end else begin
                val = (tok_mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : tok_mag;
            end
            if (tok_cnt >= 3'd2 && tok_cnt <= 3'd4) parsed_vals[tok_cnt - 3'd2] = val[15:0];
        end
        tok_phase = PH_BETWEEN;
        tok_neg   = 1'b0;
        tok_mag   = '0;
    endtask

    task automatic shift_digit(input logic [7:0] c);
        logic [63:0] m;
        m = {32'd0, tok_mag} * 64'd10 + 64'(c - CH_ZERO);
        if (m > 64'h8000_0000) m = 64'h8000_0000;
        tok_mag   = m[31:0];
        tok_phase = PH_DIGITS;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (c == CH_COMMA) begin
            token_close();
        end else begin
            if (tok_phase == PH_BETWEEN && tok_cnt < 3'd4) begin
                tok_cnt   = tok_cnt + 3'd1;
                tok_phase = PH_LEAD;
            end
            if (tok_phase == PH_LEAD) begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    tok_phase = PH_LEAD;
                end else if (c == CH_PLUS) begin
                    tok_phase = PH_DIGITS;
                end else if (c == CH_MINUS) begin
                    tok_neg   = 1'b1;
                    tok_phase = PH_DIGITS;
                end else if (is_digit) begin
                    shift_digit(c);
                end else begin
                    tok_phase = PH_DONE;
                end
            end else if (tok_phase == PH_DIGITS) begin
                if (is_digit) shift_digit(c);
                else tok_phase = PH_DONE;
            end
        end
    endtask

    task automatic predict_poll(input logic [1:0] op, input logic [7:0] data,
                                input logic last);
        if (op == OP_TICK) begin
            if (tmr_armed) begin
                if (tmr_count != 16'hFFFF) tmr_count = tmr_count + 16'd1;
                if (tmr_count >= cfg_timeout) begin
                    tmr_armed = 1'b0;
                    ctl       = ST_ERROR;
                    push_event(EV_ERROR, 8'd0, CAUSE_TIMEOUT);
                end
            end
            case (ctl)
                ST_SEND: begin
                    tmr_count = '0;
                    tmr_armed = 1'b1;
                    parser_reset();
                    ctl = ST_REQUESTED;
                    push_event(EV_TX, cfg_req_byte, CAUSE_NONE);
                end
                ST_REQUESTED: begin
                    ctl = ST_REQUESTED;
                end
                ST_READY: begin
                    if (init_step == INIT_BUSY) init_step = INIT_DONE;
                    tmr_armed = 1'b0;
                    ctl       = ST_IDLE;
                end
                ST_ERROR: begin
                    tmr_armed = 1'b0;
                    ctl       = ST_IDLE;
                end
                default: begin
                    ctl = ST_IDLE;
                    if (init_step != INIT_DONE) begin
                        init_step = INIT_BUSY;
                        ctl       = ST_SEND;
                    end
                end
            endcase
        end else if (op == OP_BYTE) begin
            if (ctl != ST_REQUESTED) begin
                parser_reset();
                if (last) begin
                    ctl = ST_ERROR;
                    push_event(EV_ERROR, 8'd0, CAUSE_OUT_STATE);
                end
            end else begin
                if (!str_ended && msg_len < MSG_MAX) begin
                    msg_len = msg_len + 8'd1;
                    if (data == CH_NUL) begin
                        str_ended = 1'b1;
                        token_close();
                    end else begin
                        parse_char(data);
                    end
                end
                if (last) begin
                    token_close();
                    if (tok_cnt >= 3'd4) begin
                        reading = parsed_vals;
                        ctl     = ST_READY;
                        push_event(EV_READY, 8'd0, CAUSE_NONE);
                    end else begin
                        ctl = ST_ERROR;
                        push_event(EV_ERROR, 8'd0, CAUSE_FEW_VALS);
                    end
                    parser_reset();
                end
            end
        end else if (op == OP_REQUEST && ctl == ST_IDLE) begin
            ctl = ST_SEND;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : event_check
        t_sensor_event want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (awaited_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event %0d", m_axis_tuser));
            end else begin
                want = awaited_events.pop_front();
                check_field("event", 16'(m_axis_tuser), 16'(want.ev));
                check_field("tx_byte", 16'(m_axis_tdata[7:0]), 16'(want.tx));
                check_field("so2_ppb", m_axis_tdata[23:8], want.so2);
                check_field("temp_centi", m_axis_tdata[39:24], want.temp);
                check_field("rh_x100", m_axis_tdata[55:40], want.rh);
                check_field("error_cause", 16'(m_axis_tdata[57:56]), 16'(want.cause));
                check_field("initialized", 16'(m_axis_tdata[58]), 16'(want.init_done));
                check_field("padding", 16'(m_axis_tdata[63:59]), 16'd0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) stall_left = stall_left - 1;
        else if (sink_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                             input logic last);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_poll(op, data, last);
        if (op != OP_UNUSED) poll_items++;
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op);
        send_item(op, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i], mark_last && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] timeout, input logic [7:0] req_byte);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        cfg_timeout = timeout;
        i_cfg_idx  <= CFG_REQ_BYTE;
        i_cfg_data <= {8'd0, req_byte};
        @(posedge i_clk);
        cfg_req_byte = req_byte;
        i_cfg_we <= 1'b0;
    endtask

    task automatic build_message();
        int unsigned tokens;
        int unsigned n_digits;
        int unsigned r;
        msg_buf.delete();
        if ($urandom_range(0, 29) == 0)
            repeat ($urandom_range(240, 280)) msg_buf.push_back(CH_SPACE);
        r = $urandom_range(0, 9);
        tokens = (r < 7) ? 4 : ((r < 9) ? $urandom_range(5, 6) : $urandom_range(0, 3));
        for (int i = 0; i < tokens; i++) begin
            if (i != 0) msg_buf.push_back(CH_COMMA);
            if ($urandom_range(0, 9) == 0) msg_buf.push_back(CH_COMMA);
            if ($urandom_range(0, 3) == 0)
                msg_buf.push_back($urandom_range(0, 1) ? CH_SPACE
                                                       : 8'($urandom_range(CH_TAB, CH_CR)));
            r = $urandom_range(0, 5);
            if (r == 0) msg_buf.push_back(CH_PLUS);
            else if (r == 1) msg_buf.push_back(CH_MINUS);
            r = $urandom_range(0, 19);
            n_digits = (r == 0) ? 0 : ((r == 1) ? $urandom_range(10, 12) : $urandom_range(1, 5));
            repeat (n_digits) msg_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0) msg_buf.push_back(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 1) == 1 || msg_buf.size() == 0) msg_buf.push_back(CH_CR);
        if ($urandom_range(0, 24) == 0)
            msg_buf.insert($urandom_range(0, msg_buf.size() - 1), CH_NUL);
    endtask

    task automatic run_random_poll();
        int unsigned r;
        bit          mark_last;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 8)) send_item(2'($urandom), 8'($urandom), 1'($urandom));
        end else begin
            if (r < 20) send_op(OP_TICK);
            send_op(OP_REQUEST);
            send_op(OP_TICK);
            build_message();
            mark_last = ($urandom_range(0, 19) != 0);
            foreach (msg_buf[i]) begin
                if ($urandom_range(0, 15) == 0) send_op(OP_TICK);
                send_item(OP_BYTE, msg_buf[i], mark_last && (i == msg_buf.size() - 1));
            end
            send_op(OP_TICK);
        end
    endtask

    task automatic test_first_poll();
        send_op(OP_TICK);
        send_op(OP_TICK);
        send_text(",7,-8, +,1", 1'b1);
        send_op(OP_TICK);
    endtask

    task automatic test_error_paths();
        send_item(OP_BYTE, "x", 1'b0);
        send_item(OP_BYTE, 8'hFF, 1'b1);
        send_op(OP_TICK);
        send_op(OP_UNUSED);
        send_op(OP_REQUEST);
        send_op(OP_REQUEST);
        send_op(OP_TICK);
        send_text("5,", 1'b0);
        send_item(OP_BYTE, CH_NUL, 1'b0);
        send_item(OP_BYTE, "9", 1'b1);
        send_op(OP_TICK);
    endtask

    task automatic test_timeout_limits();
        set_config(16'd1, 8'hFF);
        send_op(OP_REQUEST);
        send_op(OP_TICK);
        send_op(OP_TICK);
        send_op(OP_TICK);
        set_config(16'd0, 8'h00);
        send_op(OP_REQUEST);
        send_op(OP_TICK);
        send_text("1,2", 1'b0);
        send_op(OP_TICK);
        send_text("3", 1'b1);
        send_op(OP_TICK);
    endtask

    task automatic test_random_polls();
        int unsigned target;
        int unsigned phase_no;
        target   = poll_items + RANDOM_ITEMS;
        phase_no = 0;
        while (poll_items < target) begin
            case (phase_no % 6)
                0: set_config(16'hFFFF, 8'($urandom));
                1: set_config(16'd0, 8'h00);
                2: set_config(16'($urandom_range(2, 8)), 8'hFF);
                3: set_config(16'($urandom_range(9, 200)), 8'($urandom));
                4: set_config(TIMEOUT_RESET, REQ_BYTE_RESET);
                default: set_config(16'd1, 8'($urandom));
            endcase
            src_gaps    = (phase_no % 4) != 3;
            sink_stalls = src_gaps;
            repeat (6) run_random_poll();
            phase_no++;
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_poll();
        test_error_paths();
        test_timeout_limits();
        test_random_polls();
        wait_idle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(20 * 500000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
src/uspp_pkg.sv
src/uspp_front.sv
src/uspp_queue.sv
src/uspp_back.sv
src/uart_sensor_poll_csv_parser.sv
tb/uart_sensor_poll_csv_parser_tb.sv
